[rtl/mavg_pkg.sv]
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared word types, register map and controller interface of the
// moving average filter.
// ----------------------------------------------------------------------------
package mavg_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WIN_REG_W  = 7;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [WIN_REG_W-1:0] WIN_RESET  = 7'd11;
  localparam logic [0:0]           REG_WINDOW = 1'b0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_signal;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic                       last_out;
  } out_word_t;

  typedef struct packed {
    logic latch;
    logic update;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic produce;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/mavg_regs.sv]
// ----------------------------------------------------------------------------
// mavg_regs
// APB register slice: window length register and effective window.
// ----------------------------------------------------------------------------
module mavg_regs #(
  parameter int MAX_WINDOW = 64,
  parameter int WIN_W      = $clog2(MAX_WINDOW + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mavg_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [mavg_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [mavg_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [WIN_W-1:0]                  win_o,
  output logic                              restart_o
);
  import mavg_pkg::*;

  logic [WIN_REG_W-1:0] win_q, win_d;
  logic                 hit;
  logic [31:0]          win_ext;

  assign pready = 1'b1;
  assign hit    = psel && penable && pwrite && (paddr[2:2] == REG_WINDOW);
  assign win_d  = hit ? pwdata[WIN_REG_W-1:0] : win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_RESET;
    end else begin
      win_q <= win_d;
    end
  end

  assign restart_o = hit;
  assign prdata    = (paddr[2:2] == REG_WINDOW) ?
                     APB_DATA_W'(win_q) : '0;

  assign win_ext = 32'(win_q);

  always_comb begin
    if (win_ext == 32'd0) begin
      win_o = WIN_W'(1);
    end else if (win_ext > 32'(MAX_WINDOW)) begin
      win_o = WIN_W'(MAX_WINDOW);
    end else begin
      win_o = WIN_W'(win_ext);
    end
  end

endmodule

[rtl/mavg_ctrl.sv]
// ----------------------------------------------------------------------------
// mavg_ctrl
// Sequencer: take a word, update the window and, when the window yields an
// average, run the divider and hand the average off to the output register.
// ----------------------------------------------------------------------------
module mavg_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  mavg_pkg::dp_status_t   status_i,
  output mavg_pkg::ctrl_cmd_t    cmd_o
);
  import mavg_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = status_i.produce ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/mavg_dp.sv]
// ----------------------------------------------------------------------------
// mavg_dp
// Datapath: delay line memory, running sum, fill count, serial divider
// and output register.
// ----------------------------------------------------------------------------
module mavg_dp #(
  parameter int MAX_WINDOW = 64,
  parameter int WIN_W      = $clog2(MAX_WINDOW + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mavg_pkg::ctrl_cmd_t   cmd_i,
  output mavg_pkg::dp_status_t  status_o,
  input  mavg_pkg::in_word_t    in_word_i,
  input  logic [WIN_W-1:0]      win_i,
  input  logic                  restart_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output mavg_pkg::out_word_t   out_word_o
);
  import mavg_pkg::*;

  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W = SAMPLE_W + PTR_W;
  localparam int CNT_W = $clog2(SUM_W);

  logic signed [SAMPLE_W-1:0] mem [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] rd_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       last_q;

  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic [WIN_W-1:0]           fill_q, fill_d;
  logic [PTR_W-1:0]           wp_q, wp_d, old_addr;
  logic                       full;
  logic [WIN_W:0]             fill_inc;

  logic [WIN_W-1:0]           rem_q, rem_d;
  logic [SUM_W-1:0]           quo_q, quo_d;
  logic                       neg_q;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [WIN_W:0]             trial, diff;
  logic                       div_start;
  logic [SUM_W-1:0]           mag;
  logic [SUM_W-1:0]           quo_signed;

  logic                       out_valid_q, out_valid_d;
  out_word_t                  out_word_q;

  assign full     = (fill_q >= win_i);
  assign fill_inc = (WIN_W + 1)'(fill_q) + (WIN_W + 1)'(1);
  assign status_o.produce  = full || (fill_inc == (WIN_W + 1)'(win_i));
  assign status_o.div_done = cmd_i.div_step && (cnt_q == CNT_W'(SUM_W - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (32'(wp_q) >= 32'(win_i)) begin
      old_addr = PTR_W'(32'(wp_q) - 32'(win_i));
    end else begin
      old_addr = PTR_W'(32'(wp_q) + 32'(MAX_WINDOW) - 32'(win_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      rd_q     <= mem[old_addr];
      sample_q <= in_word_i.sample;
      last_q   <= in_word_i.last_of_signal;
    end
    if (cmd_i.update) begin
      mem[wp_q] <= sample_q;
    end
  end

  always_comb begin
    sum_d  = sum_q - (full ? SUM_W'(rd_q) : '0) + SUM_W'(sample_q);
    fill_d = full ? win_i : fill_inc[WIN_W-1:0];
    wp_d   = (32'(wp_q) == MAX_WINDOW - 1) ? '0 : wp_q + PTR_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      fill_q <= '0;
      wp_q   <= '0;
    end else if (restart_i || (cmd_i.update && last_q)) begin
      sum_q  <= '0;
      fill_q <= '0;
      wp_q   <= '0;
    end else if (cmd_i.update) begin
      sum_q  <= sum_d;
      fill_q <= fill_d;
      wp_q   <= wp_d;
    end
  end

  // restoring divide of the sum magnitude, one quotient bit per cycle
  assign div_start = cmd_i.update && status_o.produce;
  assign mag       = sum_d[SUM_W-1] ? SUM_W'(-sum_d) : SUM_W'(sum_d);
  assign trial     = {rem_q, quo_q[SUM_W-1]};
  assign diff      = trial - {1'b0, win_i};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (div_start) begin
      rem_d = '0;
      quo_d = mag;
      cnt_d = '0;
    end else if (cmd_i.div_step) begin
      rem_d = diff[WIN_W] ? trial[WIN_W-1:0] : diff[WIN_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], !diff[WIN_W]};
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (div_start) begin
      neg_q <= sum_d[SUM_W-1];
    end
  end

  assign quo_signed = neg_q ? -quo_q : quo_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_word_q.average  <= quo_signed[SAMPLE_W-1:0];
      out_word_q.last_out <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[rtl/moving_average_filter.sv]
// ----------------------------------------------------------------------------
// moving_average_filter
// Boxcar moving average over signed Q1.15 samples with an APB window
// length register.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        input      in_valid/in_ready    in_word_t  (sample, last flag)
//  out       output     out_valid/out_ready  out_word_t (average, last flag)
//  cfg       input      APB write/read       window length at byte address 0
//
//  A word that yields an average passes latch, update, the divider and the
//  output load, the divider giving one quotient bit per cycle; a word that
//  yields none passes latch and update only. Reset clears sum, fill count and
//  write pointer; the delay line needs no clearing. A stalled output holds in
//  the output register while the next word is taken and processed.
// ----------------------------------------------------------------------------
module moving_average_filter #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  mavg_pkg::in_word_t              in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output mavg_pkg::out_word_t             out_word_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mavg_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mavg_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mavg_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import mavg_pkg::*;

  localparam int WIN_W = $clog2(MAX_WINDOW + 1);

  logic [WIN_W-1:0] win;
  logic             restart;
  ctrl_cmd_t        cmd;
  dp_status_t       status;

  mavg_regs #(
    .MAX_WINDOW (MAX_WINDOW),
    .WIN_W      (WIN_W)
  ) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .win_o     (win),
    .restart_o (restart)
  );

  mavg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mavg_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .WIN_W      (WIN_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_word_i   (in_word_i),
    .win_i       (win),
    .restart_i   (restart),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

[rtl/mavg_checker.sv]
// ----------------------------------------------------------------------------
// mavg_checker
// Port-level checks of the moving average filter, bound to the top level.
// ----------------------------------------------------------------------------
module mavg_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input mavg_pkg::out_word_t  out_word_o
);
  import mavg_pkg::*;

  logic in_take;
  assign in_take = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> !in_ready_o)
    else $error("input taken while a word is in progress");

  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> !$rose(out_valid_o))
    else $error("average appeared right after input");

  a_ready_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("controller not idle after loading output");

endmodule

bind moving_average_filter mavg_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
